// ----- hdl/drv_i2t_pkg.sv -----
`timescale 1ns / 1ps
// Package for the I^2*t overload guard: fixed-point format, port widths,
// register indexes and saturation constants.
// No dependencies.

package drv_i2t_pkg;

    // Fixed-point format of currents, times and heat
    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int VAL_W       = VALUE_WIDTH - 1;   // unsigned magnitude width
    localparam int DIV_SHIFT   = VAL_W - FRAC_BITS; // ratio overflow test shift

    // Field widths
    localparam int CUR_W  = VALUE_WIDTH;
    localparam int TIME_W = VAL_W;

    // Stream payloads, padded to whole bytes
    localparam int IN_USED_W   = CUR_W + TIME_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W  = 1 + VAL_W + VAL_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VAL_W;

    localparam logic [CFG_IDX_W-1:0] REG_GUARD_ENABLE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_MODE       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CURRENT    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_CURRENT = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_LIMIT      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_STEP       = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_COOL_STEP       = CFG_IDX_W'(7);

    // Saturation bound and fixed-point one
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {VAL_W{1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] ONE_FX  = VALUE_WIDTH'(1) << FRAC_BITS;

endpackage

// ----- hdl/drive_i2t_overload_guard_top.sv -----
`timescale 1ns / 1ps
// Top level of the I^2*t overload guard: microcoded sequencer driving a
// shared multiplier, a radix-2 divider and the heat accumulator.
// Depends on drv_i2t_pkg.
//
//  Channel    Direction  Handshake                    Payload
//  s_axis     in         s_axis_tvalid/s_axis_tready  motor_current, elapsed_time
//  m_axis     out        m_axis_tvalid/m_axis_tready  overload_flag, available_current,
//                                                     heat_level
//  cfg        in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  A tick clears the guard state when disabled, cools when the current is not above
//  the allowed value, and otherwise heats by the fixed step or, in thermal mode, by the
//  squared ratio term; the ratio comes from 31 iterations of the one-bit-per-cycle
//  divider unless it saturates. Each tick loads the result and returns to the wait step.
//  Input is taken only while the sequencer sits at its wait step; a result waiting
//  in the output register stalls the sequencer only when the next result is ready.
//  Reset clears the configuration, the heat, the flag and the sequencer.
//  Configuration writes are taken in every cycle and are meant for idle periods.

module drive_i2t_overload_guard_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // [31:0] motor_current, [62:32] elapsed_time, [63] zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [drv_i2t_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] overload_flag, [31:1] available_current, [62:32] heat_level, [63] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [drv_i2t_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [drv_i2t_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [drv_i2t_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int VW     = drv_i2t_pkg::VALUE_WIDTH;
    localparam int VAL_W  = drv_i2t_pkg::VAL_W;
    localparam int UPC_W  = 5;
    localparam int CNT_W  = $clog2(VAL_W + 1);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_EMIT,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SAT_RATIO,
        OP_SQ_LOAD,
        OP_MUL,
        OP_SQ_SUB,
        OP_FIX_LOAD,
        OP_HEAT,
        OP_COOL_LOAD,
        OP_COOL,
        OP_CLEAR
    } uop_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_DISABLED,
        C_NOT_HOT,
        C_FIXED,
        C_DIV_SAT,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t              op;
        cond_t             cond;
        logic [UPC_W-1:0]  target;
    } ctrl_word_t;

    // Program addresses
    localparam logic [UPC_W-1:0] A_EMIT       = UPC_W'(0);
    localparam logic [UPC_W-1:0] A_WAIT       = UPC_W'(1);
    localparam logic [UPC_W-1:0] A_CHK_EN     = UPC_W'(2);
    localparam logic [UPC_W-1:0] A_CHK_HOT    = UPC_W'(3);
    localparam logic [UPC_W-1:0] A_CHK_MODE   = UPC_W'(4);
    localparam logic [UPC_W-1:0] A_DIV_INIT   = UPC_W'(5);
    localparam logic [UPC_W-1:0] A_DIV_STEP   = UPC_W'(6);
    localparam logic [UPC_W-1:0] A_SQ_LOAD    = UPC_W'(7);
    localparam logic [UPC_W-1:0] A_SQ_MUL     = UPC_W'(8);
    localparam logic [UPC_W-1:0] A_SQ_SUB     = UPC_W'(9);
    localparam logic [UPC_W-1:0] A_TH_MUL     = UPC_W'(10);
    localparam logic [UPC_W-1:0] A_FIX_LOAD   = UPC_W'(11);
    localparam logic [UPC_W-1:0] A_FIX_MUL    = UPC_W'(12);
    localparam logic [UPC_W-1:0] A_HEAT       = UPC_W'(13);
    localparam logic [UPC_W-1:0] A_COOL_LOAD  = UPC_W'(14);
    localparam logic [UPC_W-1:0] A_COOL_MUL   = UPC_W'(15);
    localparam logic [UPC_W-1:0] A_COOL       = UPC_W'(16);
    localparam logic [UPC_W-1:0] A_SAT_RATIO  = UPC_W'(17);
    localparam logic [UPC_W-1:0] A_CLEAR      = UPC_W'(18);

    // Microcode store: one control word per step
    function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        case (addr)
            A_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: A_EMIT};
            A_WAIT:      w = '{op: OP_LOAD,      cond: C_NO_IN,    target: A_WAIT};
            A_CHK_EN:    w = '{op: OP_NOP,       cond: C_DISABLED, target: A_CLEAR};
            A_CHK_HOT:   w = '{op: OP_NOP,       cond: C_NOT_HOT,  target: A_COOL_LOAD};
            A_CHK_MODE:  w = '{op: OP_NOP,       cond: C_FIXED,    target: A_FIX_LOAD};
            A_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: C_DIV_SAT,  target: A_SAT_RATIO};
            A_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: A_DIV_STEP};
            A_SQ_LOAD:   w = '{op: OP_SQ_LOAD,   cond: C_NEXT,     target: A_EMIT};
            A_SQ_MUL:    w = '{op: OP_MUL,       cond: C_NEXT,     target: A_EMIT};
            A_SQ_SUB:    w = '{op: OP_SQ_SUB,    cond: C_NEXT,     target: A_EMIT};
            A_TH_MUL:    w = '{op: OP_MUL,       cond: C_ALWAYS,   target: A_HEAT};
            A_FIX_LOAD:  w = '{op: OP_FIX_LOAD,  cond: C_NEXT,     target: A_EMIT};
            A_FIX_MUL:   w = '{op: OP_MUL,       cond: C_NEXT,     target: A_EMIT};
            A_HEAT:      w = '{op: OP_HEAT,      cond: C_ALWAYS,   target: A_EMIT};
            A_COOL_LOAD: w = '{op: OP_COOL_LOAD, cond: C_NEXT,     target: A_EMIT};
            A_COOL_MUL:  w = '{op: OP_MUL,       cond: C_NEXT,     target: A_EMIT};
            A_COOL:      w = '{op: OP_COOL,      cond: C_ALWAYS,   target: A_EMIT};
            A_SAT_RATIO: w = '{op: OP_SAT_RATIO, cond: C_ALWAYS,   target: A_SQ_LOAD};
            A_CLEAR:     w = '{op: OP_CLEAR,     cond: C_ALWAYS,   target: A_EMIT};
            default:     w = '{op: OP_NOP,       cond: C_ALWAYS,   target: A_WAIT};
        endcase
        return w;
    endfunction

    // Sequencer and control state
    logic [UPC_W-1:0]  upc_reg;
    logic [UPC_W-1:0]  upc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    ctrl_word_t        cw;
    logic              cond_true;
    logic              out_busy;

    // Configuration registers
    logic              enable_reg;
    logic              mode_reg;
    logic [VAL_W-1:0]  base_reg;
    logic [VAL_W-1:0]  max_reg;
    logic [VAL_W-1:0]  allowed_reg;
    logic [VAL_W-1:0]  limit_reg;
    logic [VAL_W-1:0]  heat_step_reg;
    logic [VAL_W-1:0]  cool_step_reg;

    // Guard state
    logic [VAL_W-1:0]  acc_reg;
    logic              flag_reg;

    // Datapath registers
    logic signed [drv_i2t_pkg::CUR_W-1:0] cur_reg;
    logic [drv_i2t_pkg::TIME_W-1:0]       time_reg;
    logic signed [VW-1:0]                 a_reg;
    logic signed [VW-1:0]                 b_reg;
    logic signed [2*VW-1:0]               prod_reg;
    logic [VW-1:0]                        rem_reg;
    logic [VAL_W-1:0]                     dvd_reg;
    logic [drv_i2t_pkg::OUT_DATA_W-1:0]   out_data_reg;

    // Datapath combinational values
    logic signed [2*VW-1:0]  prod_shift;
    logic signed [VW-1:0]    prod_sat;
    logic [VW-1:0]           div_trial;
    logic                    div_fits;
    logic                    div_sat;
    logic                    hot;
    logic signed [VW:0]      heat_sum;
    logic signed [VW:0]      cool_diff;
    logic signed [VW:0]      limit_ext;

    assign cw = ucode(upc_reg);

    // Scale the product back to the fixed-point format and clip at the top
    assign prod_shift = prod_reg >>> drv_i2t_pkg::FRAC_BITS;
    assign prod_sat   = (prod_shift > $signed({{VW{1'b0}}, drv_i2t_pkg::VAL_MAX}))
                        ? $signed(drv_i2t_pkg::VAL_MAX) : prod_shift[VW-1:0];

    // One restoring division step; ratio saturates when quotient needs more bits
    assign div_trial = {rem_reg[VAL_W-1:0], dvd_reg[VAL_W-1]};
    assign div_fits  = div_trial >= {1'b0, base_reg};
    assign div_sat   = (base_reg == '0) ||
                       (VAL_W'(cur_reg[VAL_W-1:drv_i2t_pkg::DIV_SHIFT]) >= base_reg);

    assign hot       = cur_reg > $signed({1'b0, allowed_reg});
    assign limit_ext = $signed({2'b00, limit_reg});
    assign heat_sum  = $signed({2'b00, acc_reg}) + $signed({prod_sat[VW-1], prod_sat});
    assign cool_diff = $signed({2'b00, acc_reg}) - $signed({prod_sat[VW-1], prod_sat});

    assign out_busy = out_valid_reg && !m_axis_tready;

    // Evaluate the jump condition of the current control word
    always_comb
    begin
        case (cw.cond)
            C_NEXT:     cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_IN:    cond_true = !s_axis_tvalid;
            C_DISABLED: cond_true = !enable_reg;
            C_NOT_HOT:  cond_true = !hot;
            C_FIXED:    cond_true = !mode_reg;
            C_DIV_SAT:  cond_true = div_sat;
            C_DIV_MORE: cond_true = cnt_reg != CNT_W'(1);
            C_OUT_BUSY: cond_true = out_busy;
            default:    cond_true = 1'b1;
        endcase
        upc_next = cond_true ? cw.target : upc_reg + UPC_W'(1);
    end

    // Hold sequencer, configuration, guard state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_WAIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            base_reg      <= '0;
            max_reg       <= '0;
            allowed_reg   <= '0;
            limit_reg     <= '0;
            heat_step_reg <= '0;
            cool_step_reg <= '0;
            acc_reg       <= '0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;

            // Take configuration writes; disabling clears the guard state
            if (cfg_valid)
            begin
                case (cfg_index)
                    drv_i2t_pkg::REG_GUARD_ENABLE:
                    begin
                        enable_reg <= cfg_data[0];
                        if (!cfg_data[0])
                        begin
                            acc_reg  <= '0;
                            flag_reg <= 1'b0;
                        end
                    end
                    drv_i2t_pkg::REG_HEAT_MODE:       mode_reg      <= cfg_data[0];
                    drv_i2t_pkg::REG_BASE_CURRENT:    base_reg      <= cfg_data;
                    drv_i2t_pkg::REG_MAX_CURRENT:     max_reg       <= cfg_data;
                    drv_i2t_pkg::REG_ALLOWED_CURRENT: allowed_reg   <= cfg_data;
                    drv_i2t_pkg::REG_HEAT_LIMIT:      limit_reg     <= cfg_data;
                    drv_i2t_pkg::REG_HEAT_STEP:       heat_step_reg <= cfg_data;
                    drv_i2t_pkg::REG_COOL_STEP:       cool_step_reg <= cfg_data;
                    default:                          ;
                endcase
            end

            // Advance the divider count
            case (cw.op)
                OP_DIV_INIT: cnt_reg <= CNT_W'(VAL_W);
                OP_DIV_STEP: cnt_reg <= cnt_reg - CNT_W'(1);
                default:     ;
            endcase

            // Update heat and flag
            case (cw.op)
                OP_HEAT:
                begin
                    if (heat_sum >= limit_ext)
                    begin
                        acc_reg  <= limit_reg;
                        flag_reg <= 1'b1;
                    end
                    else if (heat_sum < 0)
                    begin
                        acc_reg <= '0;
                    end
                    else
                    begin
                        acc_reg <= heat_sum[VAL_W-1:0];
                    end
                end
                OP_COOL:
                begin
                    if (cool_diff <= 0)
                    begin
                        acc_reg  <= '0;
                        flag_reg <= 1'b0;
                    end
                    else
                    begin
                        acc_reg <= cool_diff[VAL_W-1:0];
                    end
                end
                OP_CLEAR:
                begin
                    acc_reg  <= '0;
                    flag_reg <= 1'b0;
                end
                default: ;
            endcase

            // Present a result; drop valid once the transfer completes
            if (cw.op == OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    cur_reg  <= $signed(s_axis_tdata[drv_i2t_pkg::CUR_W-1:0]);
                    time_reg <= s_axis_tdata[drv_i2t_pkg::IN_USED_W-1:drv_i2t_pkg::CUR_W];
                end
            end
            OP_DIV_INIT:
            begin
                rem_reg <= VW'(cur_reg[VAL_W-1:drv_i2t_pkg::DIV_SHIFT]);
                dvd_reg <= {cur_reg[drv_i2t_pkg::DIV_SHIFT-1:0],
                            {drv_i2t_pkg::FRAC_BITS{1'b0}}};
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_fits ? div_trial - {1'b0, base_reg} : div_trial;
                dvd_reg <= {dvd_reg[VAL_W-2:0], div_fits};
            end
            OP_SAT_RATIO:
            begin
                dvd_reg <= drv_i2t_pkg::VAL_MAX[VAL_W-1:0];
            end
            OP_SQ_LOAD:
            begin
                a_reg <= $signed({1'b0, dvd_reg});
                b_reg <= $signed({1'b0, dvd_reg});
            end
            OP_MUL:
            begin
                prod_reg <= a_reg * b_reg;
            end
            OP_SQ_SUB:
            begin
                a_reg <= prod_sat - $signed(drv_i2t_pkg::ONE_FX);
                b_reg <= $signed({1'b0, time_reg});
            end
            OP_FIX_LOAD:
            begin
                a_reg <= $signed({1'b0, heat_step_reg});
                b_reg <= $signed({1'b0, time_reg});
            end
            OP_COOL_LOAD:
            begin
                a_reg <= $signed({1'b0, cool_step_reg});
                b_reg <= $signed({1'b0, time_reg});
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_data_reg <= drv_i2t_pkg::OUT_DATA_W'(
                        {acc_reg, (flag_reg ? base_reg : max_reg), flag_reg});
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (upc_reg == A_WAIT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

// ----- hdl/drv_i2t_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the I^2*t overload guard, bound to the top level.
// Depends on drv_i2t_pkg and drive_i2t_overload_guard_top.

module drv_i2t_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [drv_i2t_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // One tick at a time: an input transfer closes the input side
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a tick is in progress");

    // A new result appears exactly as the sequencer returns to its wait step
    a_result_with_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
        else $error("result raised outside the end of a tick");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Padding above the result fields stays zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[drv_i2t_pkg::OUT_DATA_W-1:drv_i2t_pkg::OUT_USED_W] == '0)
        else $error("result padding not zero");

endmodule

bind drive_i2t_overload_guard_top drv_i2t_checker u_drv_i2t_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for drive_i2t_overload_guard_top: directed and random current ticks,
// each result checked against an in-bench model of the heat accumulator and flag.
// Depends on drv_i2t_pkg and drive_i2t_overload_guard_top.

module tb_top;
    import drv_i2t_pkg::*;

    localparam longint SAT_VAL    = (longint'(1) << VAL_W) - 1;
    localparam longint UNIT       = longint'(1) << FRAC_BITS;
    localparam int     HEAT_LSB   = 1 + VAL_W;

    typedef struct {
        bit             enable;
        bit             thermal;
        bit [VAL_W-1:0] base;
        bit [VAL_W-1:0] maxc;
        bit [VAL_W-1:0] allowed;
        bit [VAL_W-1:0] limit;
        bit [VAL_W-1:0] heat_rate;
        bit [VAL_W-1:0] cool_rate;
    } guard_cfg_t;

    typedef struct {
        bit             flag;
        bit [VAL_W-1:0] avail;
        bit [VAL_W-1:0] heat;
    } guard_out_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Model state, kept in step with the accepted transfers
    guard_cfg_t active_cfg;
    longint     heat_acc;
    bit         overloaded;
    guard_out_t owed_outputs[$];
    int         mismatch_count = 0;
    bit         steady;

    drive_i2t_overload_guard_top dut (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heat model
    // ------------------------------------------------------------------
    function automatic longint sat_heat(longint v);
        return (v > SAT_VAL) ? SAT_VAL : v;
    endfunction

    // Fixed-point product of two nonnegative values, floored and saturated
    function automatic longint fx_mul(longint a, longint b);
        return sat_heat((a * b) >>> FRAC_BITS);
    endfunction

    // ((I/base)^2 - 1) * dt; a negative result rounds away from zero
    function automatic longint thermal_rise(longint amps, longint dt);
        longint ratio;
        longint square;
        longint excess;
        if (active_cfg.base == 0)
            ratio = SAT_VAL;
        else
            ratio = sat_heat((amps <<< FRAC_BITS) / longint'(active_cfg.base));
        square = fx_mul(ratio, ratio);
        excess = square - UNIT;
        if (excess >= 0)
            return fx_mul(excess, dt);
        return -(((-excess) * dt + UNIT - 1) >>> FRAC_BITS);
    endfunction

    // Advance heat and flag by one tick and return the outputs it produces
    function automatic guard_out_t advance_heat(logic signed [CUR_W-1:0] amps_in,
                                                logic [TIME_W-1:0] dt_in);
        longint     amps;
        longint     dt;
        longint     h;
        guard_out_t res;
        amps = longint'(amps_in);
        dt   = longint'(dt_in);
        if (!active_cfg.enable)
        begin
            heat_acc   = 0;
            overloaded = 1'b0;
        end
        else if (amps > longint'(active_cfg.allowed))
        begin
            h = heat_acc + (active_cfg.thermal ? thermal_rise(amps, dt)
                                               : fx_mul(longint'(active_cfg.heat_rate), dt));
            if (h >= longint'(active_cfg.limit))
            begin
                h          = longint'(active_cfg.limit);
                overloaded = 1'b1;
            end
            if (h < 0)
                h = 0;
            heat_acc = h;
        end
        else
        begin
            h = heat_acc - fx_mul(longint'(active_cfg.cool_rate), dt);
            if (h <= 0)
            begin
                h          = 0;
                overloaded = 1'b0;
            end
            heat_acc = h;
        end
        res.flag  = overloaded;
        res.avail = overloaded ? active_cfg.base : active_cfg.maxc;
        res.heat  = heat_acc[VAL_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic bit [VAL_W-1:0] rand_mag();
        return VAL_W'($urandom) >> $urandom_range(0, VAL_W - 1);
    endfunction

    // Send one tick; tvalid stays high so a back-to-back tick needs no gap
    task automatic send_tick(logic signed [CUR_W-1:0] amps, logic [TIME_W-1:0] dt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({dt, amps});
        do @(posedge clk); while (!s_axis_tready);
        owed_outputs.push_back(advance_heat(amps, dt));
    endtask

    // Drop tvalid and hold until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (owed_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register transfer; cfg_valid is left high for the next one
    task automatic cfg_transfer(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GUARD_ENABLE:
            begin
                active_cfg.enable = val[0];
                if (!val[0])
                begin
                    heat_acc   = 0;
                    overloaded = 1'b0;
                end
            end
            REG_HEAT_MODE:       active_cfg.thermal   = val[0];
            REG_BASE_CURRENT:    active_cfg.base      = val;
            REG_MAX_CURRENT:     active_cfg.maxc      = val;
            REG_ALLOWED_CURRENT: active_cfg.allowed   = val;
            REG_HEAT_LIMIT:      active_cfg.limit     = val;
            REG_HEAT_STEP:       active_cfg.heat_rate = val;
            REG_COOL_STEP:       active_cfg.cool_rate = val;
            default:             ;
        endcase
    endtask

    task automatic program_guard(guard_cfg_t s);
        cfg_transfer(REG_GUARD_ENABLE, CFG_DATA_W'(s.enable));
        cfg_transfer(REG_HEAT_MODE, CFG_DATA_W'(s.thermal));
        cfg_transfer(REG_BASE_CURRENT, s.base);
        cfg_transfer(REG_MAX_CURRENT, s.maxc);
        cfg_transfer(REG_ALLOWED_CURRENT, s.allowed);
        cfg_transfer(REG_HEAT_LIMIT, s.limit);
        cfg_transfer(REG_HEAT_STEP, s.heat_rate);
        cfg_transfer(REG_COOL_STEP, s.cool_rate);
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall a random number of cycles once a result shows up
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                do @(posedge clk); while (!m_axis_tvalid);
                repeat (stall - 1) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    // Print one line per mismatch and count it
    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_results
        guard_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_outputs.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            else
            begin
                want = owed_outputs.pop_front();
                if (m_axis_tdata[0] !== want.flag)
                    report_mismatch($sformatf("overload_flag got %b want %b",
                                              m_axis_tdata[0], want.flag));
                if (m_axis_tdata[VAL_W:1] !== want.avail)
                    report_mismatch($sformatf("available_current got %h want %h",
                                              m_axis_tdata[VAL_W:1], want.avail));
                if (m_axis_tdata[HEAT_LSB+VAL_W-1:HEAT_LSB] !== want.heat)
                    report_mismatch($sformatf("heat_level got %h want %h",
                                              m_axis_tdata[HEAT_LSB+VAL_W-1:HEAT_LSB],
                                              want.heat));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        guard_cfg_t s;
        // registers still at reset: every tick reports zero
        send_tick(32'sh8000_0000, 31'h7FFF_FFFF);
        send_tick(32'sh7FFF_FFFF, 31'h0000_0000);
        send_tick(32'sh0000_0000, 31'h0000_0001);
        wait_drained();
        // disabled guard still reports the maximum current
        s = '{enable: 1'b0, default: '1};
        program_guard(s);
        send_tick(32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        wait_drained();
    endtask

    task automatic test_fixed_heating();
        guard_cfg_t s;
        // base 1.0, max 2.0, allowed 1.5, limit 10.0, heat 4.0/unit, cool 2.0/unit
        s = '{enable: 1'b1, thermal: 1'b0, base: 31'h0001_0000, maxc: 31'h0002_0000,
              allowed: 31'h0001_8000, limit: 31'h000A_0000, heat_rate: 31'h0004_0000,
              cool_rate: 31'h0002_0000};
        program_guard(s);
        send_tick(32'sh0001_8000, 31'h0001_0000);      // exactly at threshold: cools
        repeat (3) send_tick(32'sh0003_0000, 31'h0001_0000); // 4, 8, clamp at 10
        send_tick(32'sh8000_0000, 31'h0001_0000);      // most negative current cools
        send_tick(32'sh0000_0000, 31'h7FFF_FFFF);      // saturated cooling clears flag
        send_tick(32'sh7FFF_FFFF, 31'h0000_0000);      // zero elapsed time
        send_tick(32'sh7FFF_FFFF, 31'h7FFF_FFFF);      // saturated heating
        wait_drained();
    endtask

    task automatic test_limit_lowered();
        guard_cfg_t s;
        // heat sits at 10.0; drop the limit to 5.0 underneath it
        s = '{enable: 1'b1, thermal: 1'b0, base: 31'h0001_0000, maxc: 31'h0002_0000,
              allowed: 31'h0001_8000, limit: 31'h0005_0000, heat_rate: 31'h0004_0000,
              cool_rate: 31'h0002_0000};
        program_guard(s);
        send_tick(32'sh0000_0000, 31'h0001_0000);      // cooling works on stored heat
        send_tick(32'sh0003_0000, 31'h0000_0100);      // heating clamps to new limit
        wait_drained();
        // clearing the enable drops heat and flag
        s.enable = 1'b0;
        program_guard(s);
        send_tick(32'sh0003_0000, 31'h0001_0000);
        wait_drained();
        s.enable = 1'b1;
        program_guard(s);
        send_tick(32'sh0003_0000, 31'h0000_4000);
        wait_drained();
    endtask

    task automatic test_thermal_heating();
        guard_cfg_t s;
        // zero base current: ratio saturates
        s = '{enable: 1'b1, thermal: 1'b1, base: 31'h0000_0000, maxc: 31'h0003_0000,
              allowed: 31'h0000_8000, limit: 31'h000A_0000, heat_rate: 31'h0000_0000,
              cool_rate: 31'h0001_0000};
        program_guard(s);
        send_tick(32'sh0001_0000, 31'h0001_0000);
        send_tick(32'sh0000_0000, 31'h7FFF_FFFF);
        wait_drained();
        // allowed below base: currents in between give a negative step
        s.base    = 31'h0001_0000;
        s.allowed = 31'h0000_4000;
        program_guard(s);
        send_tick(32'sh0003_0000, 31'h0001_0000);      // +8.0
        send_tick(32'sh0000_8000, 31'h0002_0000);      // -1.5, flag untouched
        send_tick(32'sh0004_0000, 31'h0001_0000);      // +15.0, clamps and flags
        send_tick(32'sh0000_8000, 31'h0001_0000);      // falls while flagged
        send_tick(32'sh0000_8000, 31'h7FFF_FFFF);      // floors at zero, flag stays
        send_tick(32'sh0001_0000, 31'h0001_0000);      // ratio exactly one
        wait_drained();
    endtask

    function automatic guard_cfg_t random_settings();
        guard_cfg_t s;
        s.enable  = ($urandom_range(0, 5) != 0);
        s.thermal = 1'($urandom_range(0, 1));
        s.base    = ($urandom_range(0, 5) == 0) ? rand_mag()
                  : VAL_W'($urandom_range(32'h0000_1000, 32'h0010_0000));
        s.maxc    = rand_mag();
        s.allowed = VAL_W'(sat_heat((longint'(s.base) * $urandom_range(32, 160)) >> 7));
        // thermal steps are a few units per tick, so keep the limit within reach
        s.limit   = s.thermal ? VAL_W'($urandom_range(0, 32'h0040_0000)) : rand_mag();
        s.heat_rate = s.limit >> $urandom_range(0, 5);
        s.cool_rate = s.limit >> $urandom_range(0, 6);
        return s;
    endfunction

    task automatic test_random_ticks();
        guard_cfg_t        s;
        longint            amps;
        longint            span;
        logic [TIME_W-1:0] dt;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       s = '{default: '1};
                1:       s = '{enable: 1'b1, default: '0};
                7:       s = '{thermal: 1'b0, default: '1};
                default: s = random_settings();
            endcase
            steady = (phase % 3 == 2);
            program_guard(s);
            for (int i = 0; i < 94; i++)
            begin
                // overdrive of up to three times the base current
                span = ((longint'(s.base) * $urandom_range(0, 384)) >> 7) + 1;
                case ($urandom_range(0, 9))
                    0:             amps = longint'($signed($urandom));
                    1, 2, 3, 4, 5: amps = longint'(s.allowed) + span;
                    default:       amps = longint'(s.allowed) - longint'(rand_mag());
                endcase
                if (amps > 64'sh7FFF_FFFF)
                    amps = 64'sh7FFF_FFFF;
                dt = ($urandom_range(0, 4) == 0) ? TIME_W'($urandom)
                   : TIME_W'($urandom_range(0, 32'h0003_0000));
                send_tick(amps[CUR_W-1:0], dt);
                // hold the sender once until every owed result has come back
                if (phase == 3 && i == 47)
                    wait_drained();
            end
            wait_drained();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_GUARD_ENABLE;
        cfg_data      <= '0;
        steady        = 1'b0;
        heat_acc      = 0;
        overloaded    = 1'b0;
        active_cfg    = '{default: '0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_fixed_heating();
        test_limit_lowered();
        test_thermal_heating();
        test_random_ticks();

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
